FILE: rtl/feal_pkg.sv
// Shared types, constants and round functions of the FEAL-4 pipeline.
`default_nettype none

package feal_pkg;

  // Register stages: input whitening, four rounds, output whitening
  localparam int NUM_STG = 6;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [31:0] word_t;
  typedef logic [63:0] block_t;

  // Key register indexes
  localparam cfg_idx_t CFG_KEY_M1 = 3'd0;
  localparam cfg_idx_t CFG_KEY_N1 = 3'd1;
  localparam cfg_idx_t CFG_KEY_M2 = 3'd2;
  localparam cfg_idx_t CFG_KEY_N2 = 3'd3;
  localparam cfg_idx_t CFG_KEY_M3 = 3'd4;
  localparam cfg_idx_t CFG_KEY_N3 = 3'd5;

  // Operation codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // S operation: rotate left by 2 of (a + b + d) mod 256
  function automatic logic [7:0] feal_s(input logic [7:0] a, input logic [7:0] b,
                                        input logic d);
    logic [7:0] t;
    t = a + b + {7'd0, d};
    return {t[5:0], t[7:6]};
  endfunction

  // F function, byte 0 is the most significant byte
  function automatic word_t feal_f(input word_t w);
    logic [7:0] c0, c1, c2, c3;
    c1 = feal_s(w[31:24] ^ w[23:16], w[15:8] ^ w[7:0], 1'b1);
    c2 = feal_s(w[15:8] ^ w[7:0], c1, 1'b0);
    c0 = feal_s(w[31:24], c1, 1'b0);
    c3 = feal_s(w[7:0], c2, 1'b1);
    return {c0, c1, c2, c3};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/feal_in_if.sv
// Input channel: operation bit and one 64-bit block per beat.
`default_nettype none

interface feal_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] data_block;

  modport source(output valid, output operation, output data_block, input ready);
  modport sink(input valid, input operation, input data_block, output ready);
endinterface

`default_nettype wire

FILE: rtl/feal_out_if.sv
// Result channel: one 64-bit block per beat.
`default_nettype none

interface feal_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_block;

  modport source(output valid, output result_block, input ready);
  modport sink(input valid, input result_block, output ready);
endinterface

`default_nettype wire

FILE: rtl/feal_equivalent_block_cipher_top.sv
// FEAL-4 encrypt/decrypt pipeline in key-constant form with key registers.
// Each beat passes through stage registers 0 to 5 in order; the result beat is driven
// from the last stage register, whose valid bit is out_ch.valid.
// Throughput: one block per cycle unless out_ch stalls; six register stages, one per
// F round or whitening step, with valid bits that let bubbles collapse under stall.
// Reset (synchronous, rst_n low) clears all stage valid bits and all six keys.
`default_nettype none

module feal_equivalent_block_cipher_top
  import feal_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  feal_in_if.sink       in_ch,
  feal_out_if.source    out_ch,
  input  wire logic     cfg_we,
  input  wire cfg_idx_t cfg_index,
  input  wire word_t    cfg_wdata
);

  // Key registers
  word_t key_m1_r, key_n1_r, key_m2_r, key_n2_r, key_m3_r, key_n3_r;

  // Stage registers: (u, v) pair, direction and valid
  logic  [NUM_STG-1:0] vld_r;
  logic  [NUM_STG-1:0] op_r;
  word_t               u_r [NUM_STG];
  word_t               v_r [NUM_STG];
  logic  [NUM_STG-1:0] rdy;

  word_t u_nxt [NUM_STG];
  word_t v_nxt [NUM_STG];
  word_t rkey  [NUM_STG];

  // Write key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_m1_r <= '0;
      key_n1_r <= '0;
      key_m2_r <= '0;
      key_n2_r <= '0;
      key_m3_r <= '0;
      key_n3_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_M1: key_m1_r <= cfg_wdata;
        CFG_KEY_N1: key_n1_r <= cfg_wdata;
        CFG_KEY_M2: key_m2_r <= cfg_wdata;
        CFG_KEY_N2: key_n2_r <= cfg_wdata;
        CFG_KEY_M3: key_m3_r <= cfg_wdata;
        CFG_KEY_N3: key_n3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Ready chain: a stage takes a beat when empty or when it drains downstream
  always_comb begin
    rdy[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ch.ready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_ch.ready = rdy[0];

  // Round keys: encrypt uses 0,0,M2,N2; decrypt uses N2,M2,0,0
  always_comb begin
    for (int i = 0; i < NUM_STG; i++) begin
      rkey[i] = '0;
    end
    rkey[1] = (op_r[0] == OP_DECRYPT) ? key_n2_r : '0;
    rkey[2] = (op_r[1] == OP_DECRYPT) ? key_m2_r : '0;
    rkey[3] = (op_r[2] == OP_DECRYPT) ? '0 : key_m2_r;
    rkey[4] = (op_r[3] == OP_DECRYPT) ? '0 : key_n2_r;
  end

  // Stage datapath
  always_comb begin
    logic  in_dec;
    word_t in_hi, in_lo, wk_a, wk_b, hi;
    in_dec = (in_ch.operation == OP_DECRYPT);
    in_hi  = in_ch.data_block[63:32];
    in_lo  = in_ch.data_block[31:0];
    // input whitening: encrypt with M1/N1, decrypt with N3/M3
    wk_a     = in_dec ? key_n3_r : key_m1_r;
    wk_b     = in_dec ? key_m3_r : key_n1_r;
    u_nxt[0] = in_hi ^ wk_a;
    v_nxt[0] = in_hi ^ in_lo ^ wk_b;
    // rounds: (u, v) -> (v, u ^ F(v ^ k))
    for (int i = 1; i < NUM_STG - 1; i++) begin
      u_nxt[i] = v_r[i-1];
      v_nxt[i] = u_r[i-1] ^ feal_f(v_r[i-1] ^ rkey[i]);
    end
    // output whitening: encrypt with N3/M3, decrypt with M1/N1
    hi = v_r[NUM_STG-2] ^ ((op_r[NUM_STG-2] == OP_DECRYPT) ? key_m1_r : key_n3_r);
    u_nxt[NUM_STG-1] = hi;
    v_nxt[NUM_STG-1] = u_r[NUM_STG-2] ^ hi ^
                       ((op_r[NUM_STG-2] == OP_DECRYPT) ? key_n1_r : key_m3_r);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int i = 1; i < NUM_STG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Advance payload; hold while stalled
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      op_r[0] <= in_ch.operation;
    end
    for (int i = 1; i < NUM_STG; i++) begin
      if (rdy[i]) begin
        op_r[i] <= op_r[i-1];
      end
    end
    for (int i = 0; i < NUM_STG; i++) begin
      if (rdy[i]) begin
        u_r[i] <= u_nxt[i];
        v_r[i] <= v_nxt[i];
      end
    end
  end

  assign out_ch.valid        = vld_r[NUM_STG-1];
  assign out_ch.result_block = {u_r[NUM_STG-1], v_r[NUM_STG-1]};

`ifndef SYNTHESIS
  // An accepted beat lands in the first stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted input beat not captured");

  // Input stalls only when every stage is full
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&vld_r))
    else $error("input stalled with a bubble in the pipeline");

  // A beat leaving the last round reaches the output stage
  a_last_move: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NUM_STG-2] && rdy[NUM_STG-1]) |=> vld_r[NUM_STG-1])
    else $error("beat lost between last round and output");

  // Stage 1, when stalled, keeps its beat
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && !rdy[1]) |=> (vld_r[1] && $stable(v_r[1])))
    else $error("stalled stage dropped or changed its beat");
`endif

endmodule

`default_nettype wire
